/* hdl/afs_lrc_pkg.sv */
package afs_lrc_pkg;

  // Line buffer and length counter limits
  localparam int LINE_MAX = 14;
  localparam logic [4:0] LINE_LEN_SAT = 5'd15;
  localparam logic [4:0] LINE_LEN_GOOD = 5'd13;
  localparam logic [4:0] LINE_LEN_WITH_CR = 5'd14;

  // Highest channel number that the slave serves (at most four exist)
  localparam logic [6:0] NUM_CHANNELS = 7'd4;

  // Characters
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Reply words
  localparam logic [31:0] WORD_FF00 = 32'h4646_3030;
  localparam logic [31:0] WORD_0000 = 32'h3030_3030;

  // Command codes
  localparam logic [6:0] CMD_READ_COIL = 7'd1;
  localparam logic [6:0] CMD_READ_INPUT = 7'd2;
  localparam logic [6:0] CMD_WRITE_COIL = 7'd5;
  localparam logic [6:0] CMD_READ_ANALOG = 7'd6;
  localparam logic [6:0] CMD_WRITE_ANALOG = 7'd7;

  // Frame status codes
  localparam logic [2:0] ST_ANSWERED = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_LRC = 3'd3;
  localparam logic [2:0] ST_OTHER_SLAVE = 3'd4;
  localparam logic [2:0] ST_BAD_COMMAND = 3'd5;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd6;

  // Reset values
  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd3;
  localparam logic [3:0] COIL_LEVELS_RESET = 4'hF;
  localparam logic [7:0] ANALOG_LEVEL_RESET = 8'hFF;

  typedef struct packed {
    logic [7:0] rx_char;
    logic [3:0] digital_inputs;
    logic [9:0] analog_in_one;
    logic [9:0] analog_in_two;
    logic [9:0] analog_in_three;
    logic [9:0] analog_in_four;
  } in_item_t;

  typedef struct packed {
    logic [2:0] frame_status;
    logic [6:0] command_code;
    logic [6:0] channel_number;
    logic [31:0] reply_data;
    logic [3:0] coil_drive;
    logic [7:0] analog_drive;
  } out_item_t;

  // Hex digit value, letters taken as c - 55, wraps like an 8-bit byte
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    return (c > CHAR_NINE) ? (c - 8'd55) : (c - 8'd48);
  endfunction

  // Byte from two hex characters, modulo 256
  function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] hn;
    hn = nibble_of(hi);
    return {hn[3:0], 4'b0000} + nibble_of(lo);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Value of a decimal character, 0 for anything else
  function automatic logic [3:0] dec_or_zero(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    return is_dec(c) ? d[3:0] : 4'd0;
  endfunction

  // Two decimal characters as a number 0..99
  function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = hi - CHAR_ZERO;
    l = lo - CHAR_ZERO;
    return ({h[3:0], 3'b000} - 7'd0) + {2'b00, h[3:0], 1'b0} + {3'b000, l[3:0]};
  endfunction

endpackage

/* hdl/ascii_frame_slave_with_lrc.sv */
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_item  (afs_lrc_pkg::in_item_t)
// out       out_valid / out_stall  out_item (afs_lrc_pkg::out_item_t)
// cfg       cfg_we                 cfg_wdata (slave address)
//
// One character per cycle while in_stall is low. A character is held in an
// input register, then added to the line buffer or, for LF, checked and
// answered into the output register, which raises out_valid.
// Synchronous active-high reset empties the line and turns all coils off.
// in_stall rises only while an LF waits for a stalled output register.
module ascii_frame_slave_with_lrc (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  afs_lrc_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output afs_lrc_pkg::out_item_t out_item,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata
);

  // Input register
  logic                  held_valid;
  afs_lrc_pkg::in_item_t held;

  // Block state
  logic [7:0] line_chars [afs_lrc_pkg::LINE_MAX];
  logic [4:0] line_length;
  logic [3:0] coil_levels;
  logic [3:0] coil_levels_next;
  logic [7:0] analog_level;
  logic [7:0] analog_level_next;
  logic [7:0] slave_address;

  // Handshake
  logic held_is_lf;
  logic out_free;
  logic advance;
  logic take_in;
  logic answer;

  // Frame checks
  logic        len_ok;
  logic [7:0]  lrc_sum;
  logic [7:0]  lrc_calc;
  logic        cmd_dec;
  logic        chan_dec;
  logic [6:0]  cmd_val;
  logic [6:0]  chan_val;
  logic        cmd_known;
  logic        chan_ok;
  logic [1:0]  bit_sel;
  logic [31:0] data_word;

  // Decimal conversion of an analog sample
  logic [9:0]  ain_sel;
  logic [17:0] q10_prod;
  logic [15:0] q100_prod;
  logic [6:0]  q10;
  logic [3:0]  q100;
  logic        q1000;
  logic [9:0]  d0_full;
  logic [6:0]  d1_full;
  logic [3:0]  d2_full;
  logic [31:0] analog_word;

  // Value written to the analog output
  logic [13:0] wr_value;

  afs_lrc_pkg::out_item_t result;

  assign held_is_lf = (held.rx_char == afs_lrc_pkg::CHAR_LF);
  assign out_free   = !out_valid || !out_stall;
  assign advance    = held_valid && (!held_is_lf || out_free);
  assign answer     = held_valid && held_is_lf && out_free;
  assign in_stall   = held_valid && !advance;
  assign take_in    = in_valid && !in_stall;

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take_in) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
    if (take_in) begin
      held <= in_item;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= afs_lrc_pkg::SLAVE_ADDRESS_RESET;
    end else if (cfg_we) begin
      slave_address <= cfg_wdata;
    end
  end

  // Collect characters; drop those past the buffer, restart the line at LF
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= 5'd0;
    end else if (advance) begin
      if (held_is_lf) begin
        line_length <= 5'd0;
      end else if (line_length < afs_lrc_pkg::LINE_LEN_SAT) begin
        line_length <= line_length + 5'd1;
      end
    end
    if (advance && !held_is_lf && (line_length < 5'(afs_lrc_pkg::LINE_MAX))) begin
      line_chars[line_length[3:0]] <= held.rx_char;
    end
  end

  // Field decode
  always_comb begin
    len_ok = (line_length == afs_lrc_pkg::LINE_LEN_GOOD) ||
             ((line_length == afs_lrc_pkg::LINE_LEN_WITH_CR) &&
              (line_chars[13] == afs_lrc_pkg::CHAR_CR));
    lrc_sum = afs_lrc_pkg::hex_byte(line_chars[1], line_chars[2]) +
              afs_lrc_pkg::hex_byte(line_chars[3], line_chars[4]) +
              afs_lrc_pkg::hex_byte(line_chars[5], line_chars[6]) +
              afs_lrc_pkg::hex_byte(line_chars[7], line_chars[8]) +
              afs_lrc_pkg::hex_byte(line_chars[9], line_chars[10]);
    lrc_calc = ~lrc_sum + 8'd1;
    cmd_dec  = afs_lrc_pkg::is_dec(line_chars[3]) && afs_lrc_pkg::is_dec(line_chars[4]);
    chan_dec = afs_lrc_pkg::is_dec(line_chars[5]) && afs_lrc_pkg::is_dec(line_chars[6]);
    cmd_val  = afs_lrc_pkg::two_digits(line_chars[3], line_chars[4]);
    chan_val = afs_lrc_pkg::two_digits(line_chars[5], line_chars[6]);
    cmd_known = (cmd_val == afs_lrc_pkg::CMD_READ_COIL) ||
                (cmd_val == afs_lrc_pkg::CMD_READ_INPUT) ||
                (cmd_val == afs_lrc_pkg::CMD_WRITE_COIL) ||
                (cmd_val == afs_lrc_pkg::CMD_READ_ANALOG) ||
                (cmd_val == afs_lrc_pkg::CMD_WRITE_ANALOG);
    chan_ok = (chan_val >= 7'd1) && (chan_val <= afs_lrc_pkg::NUM_CHANNELS) &&
              (chan_val <= 7'd4) &&
              !((cmd_val == afs_lrc_pkg::CMD_WRITE_ANALOG) && (chan_val != 7'd1));
    bit_sel   = chan_val[1:0] - 2'd1;
    data_word = {line_chars[7], line_chars[8], line_chars[9], line_chars[10]};
  end

  // Sample to four decimal digits: reciprocal multiplies, then subtract back
  always_comb begin
    case (bit_sel)
      2'd0:    ain_sel = held.analog_in_one;
      2'd1:    ain_sel = held.analog_in_two;
      2'd2:    ain_sel = held.analog_in_three;
      default: ain_sel = held.analog_in_four;
    endcase
    q10_prod  = {8'd0, ain_sel} * 18'd205;
    q100_prod = {6'd0, ain_sel} * 16'd41;
    q10   = q10_prod[17:11];
    q100  = q100_prod[15:12];
    q1000 = (ain_sel >= 10'd1000);
    d0_full = ain_sel - ({q10, 3'b000} - 10'd0) - {2'b00, q10, 1'b0};
    d1_full = q10 - {q100, 3'b000} - {2'b00, q100, 1'b0};
    d2_full = q100 - (q1000 ? 4'd10 : 4'd0);
    analog_word = {afs_lrc_pkg::CHAR_ZERO + {7'd0, q1000},
                   afs_lrc_pkg::CHAR_ZERO + {4'd0, d2_full},
                   afs_lrc_pkg::CHAR_ZERO + {1'b0, d1_full},
                   afs_lrc_pkg::CHAR_ZERO + {4'd0, d0_full[3:0]}};
  end

  // Four data characters as a decimal value
  always_comb begin
    wr_value = 14'(afs_lrc_pkg::dec_or_zero(line_chars[7])) * 14'd1000 +
               14'(afs_lrc_pkg::dec_or_zero(line_chars[8])) * 14'd100 +
               14'(afs_lrc_pkg::dec_or_zero(line_chars[9])) * 14'd10 +
               14'(afs_lrc_pkg::dec_or_zero(line_chars[10]));
  end

  // Check the line in priority order and execute the command
  always_comb begin
    result = '0;
    coil_levels_next  = coil_levels;
    analog_level_next = analog_level;
    if (!len_ok) begin
      result.frame_status = afs_lrc_pkg::ST_BAD_LENGTH;
    end else if (line_chars[0] != afs_lrc_pkg::CHAR_COLON) begin
      result.frame_status = afs_lrc_pkg::ST_BAD_START;
    end else if (lrc_calc != afs_lrc_pkg::hex_byte(line_chars[11], line_chars[12])) begin
      result.frame_status = afs_lrc_pkg::ST_BAD_LRC;
    end else if (afs_lrc_pkg::hex_byte(line_chars[1], line_chars[2]) != slave_address) begin
      result.frame_status = afs_lrc_pkg::ST_OTHER_SLAVE;
    end else if (!cmd_dec) begin
      result.frame_status = afs_lrc_pkg::ST_BAD_COMMAND;
    end else if (!cmd_known) begin
      result.frame_status = afs_lrc_pkg::ST_BAD_COMMAND;
      result.command_code = cmd_val;
    end else if (!chan_dec) begin
      result.frame_status = afs_lrc_pkg::ST_BAD_CHANNEL;
      result.command_code = cmd_val;
    end else if (!chan_ok) begin
      result.frame_status   = afs_lrc_pkg::ST_BAD_CHANNEL;
      result.command_code   = cmd_val;
      result.channel_number = chan_val;
    end else begin
      result.frame_status   = afs_lrc_pkg::ST_ANSWERED;
      result.command_code   = cmd_val;
      result.channel_number = chan_val;
      unique case (cmd_val)
        afs_lrc_pkg::CMD_READ_COIL: begin
          result.reply_data = coil_levels[bit_sel] ? afs_lrc_pkg::WORD_0000
                                                   : afs_lrc_pkg::WORD_FF00;
        end
        afs_lrc_pkg::CMD_READ_INPUT: begin
          result.reply_data = held.digital_inputs[bit_sel] ? afs_lrc_pkg::WORD_FF00
                                                           : afs_lrc_pkg::WORD_0000;
        end
        afs_lrc_pkg::CMD_WRITE_COIL: begin
          result.reply_data = data_word;
          coil_levels_next[bit_sel] = (data_word != afs_lrc_pkg::WORD_FF00);
        end
        afs_lrc_pkg::CMD_READ_ANALOG: begin
          result.reply_data = analog_word;
        end
        default: begin
          result.reply_data = data_word;
          analog_level_next = (wr_value > 14'd255) ? 8'hFF : wr_value[7:0];
        end
      endcase
    end
    result.coil_drive   = coil_levels_next;
    result.analog_drive = analog_level_next;
  end

  // Commit outputs and state when an LF is answered
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      coil_levels  <= afs_lrc_pkg::COIL_LEVELS_RESET;
      analog_level <= afs_lrc_pkg::ANALOG_LEVEL_RESET;
    end else if (answer) begin
      out_valid    <= 1'b1;
      coil_levels  <= coil_levels_next;
      analog_level <= analog_level_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (answer) begin
      out_item <= result;
    end
  end

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= afs_lrc_pkg::LINE_LEN_SAT)
    else $error("line length above saturation");

  a_lf_clears_len: assert property (@(posedge clk) disable iff (rst)
    answer |=> line_length == 5'd0)
    else $error("line length not cleared after LF");

  a_result_from_lf: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(held_valid && held_is_lf))
    else $error("result without LF");

  a_drive_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.coil_drive == coil_levels) &&
                  (out_item.analog_drive == analog_level))
    else $error("shown drive differs from output state");

endmodule

/* dv/afs_lrc_checker.sv */
`timescale 1ns / 1ps

module afs_lrc_checker
  import afs_lrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  output int        fail_count,
  output int        pending
);

  // Mirror of the slave state
  logic [7:0] line_buf [LINE_MAX];
  logic [4:0] line_len;
  logic [3:0] coil_lvl;
  logic [7:0] aout_lvl;
  logic [7:0] our_addr;
  out_item_t  answers_q [$];
  out_item_t  want;

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    return (c > CHAR_NINE) ? c - 8'd55 : c - 8'd48;
  endfunction

  // Byte from two buffered characters, wrapping modulo 256
  function automatic logic [7:0] pair_byte(input int pos);
    logic [7:0] hn;
    hn = hex_val(line_buf[pos]);
    return {hn[3:0], 4'h0} + hex_val(line_buf[pos + 1]);
  endfunction

  function automatic logic dec_char(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic int digit_of(input logic [7:0] c);
    return c - 48;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      fail_count = fail_count + 1;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  // Collect one character; at LF work out the status answer
  task automatic decode_char(input in_item_t it);
    out_item_t  ans;
    logic [7:0] sum;
    logic [7:0] lrc_calc;
    logic [7:0] d0, d1, d2, d3;
    logic [4:0] len;
    logic [9:0] sample;
    int         cmd, chn, sel, v;
    if (it.rx_char != CHAR_LF) begin
      if (line_len < LINE_MAX) line_buf[line_len] = it.rx_char;
      if (line_len < LINE_LEN_SAT) line_len = line_len + 5'd1;
    end else begin
      len = line_len;
      line_len = '0;
      ans = '0;
      ans.frame_status = ST_ANSWERED;
      cmd = 0;
      chn = 0;
      if (!(len == LINE_LEN_GOOD || (len == LINE_LEN_WITH_CR && line_buf[13] == CHAR_CR))) begin
        ans.frame_status = ST_BAD_LENGTH;
      end else if (line_buf[0] != CHAR_COLON) begin
        ans.frame_status = ST_BAD_START;
      end else begin
        sum = '0;
        for (int k = 0; k < 5; k++) sum = sum + pair_byte(1 + 2 * k);
        lrc_calc = ~sum + 8'd1;
        if (lrc_calc != pair_byte(11)) begin
          ans.frame_status = ST_BAD_LRC;
        end else if (pair_byte(1) != our_addr) begin
          ans.frame_status = ST_OTHER_SLAVE;
        end else if (!dec_char(line_buf[3]) || !dec_char(line_buf[4])) begin
          ans.frame_status = ST_BAD_COMMAND;
        end else begin
          cmd = digit_of(line_buf[3]) * 10 + digit_of(line_buf[4]);
          if (!(cmd == CMD_READ_COIL || cmd == CMD_READ_INPUT || cmd == CMD_WRITE_COIL ||
                cmd == CMD_READ_ANALOG || cmd == CMD_WRITE_ANALOG)) begin
            ans.frame_status = ST_BAD_COMMAND;
          end else if (!dec_char(line_buf[5]) || !dec_char(line_buf[6])) begin
            ans.frame_status = ST_BAD_CHANNEL;
          end else begin
            chn = digit_of(line_buf[5]) * 10 + digit_of(line_buf[6]);
            if (chn < 1 || chn > NUM_CHANNELS || chn > 4 ||
                (cmd == CMD_WRITE_ANALOG && chn != 1)) begin
              ans.frame_status = ST_BAD_CHANNEL;
            end else begin
              sel = chn - 1;
              d0 = line_buf[7];
              d1 = line_buf[8];
              d2 = line_buf[9];
              d3 = line_buf[10];
              case (chn)
                1: sample = it.analog_in_one;
                2: sample = it.analog_in_two;
                3: sample = it.analog_in_three;
                default: sample = it.analog_in_four;
              endcase
              case (cmd)
                CMD_READ_COIL: begin
                  ans.reply_data = coil_lvl[sel] ? WORD_0000 : WORD_FF00;
                end
                CMD_READ_INPUT: begin
                  ans.reply_data = it.digital_inputs[sel] ? WORD_FF00 : WORD_0000;
                end
                CMD_WRITE_COIL: begin
                  // Only FF00 turns the coil on (pin low)
                  ans.reply_data = {d0, d1, d2, d3};
                  coil_lvl[sel] = (ans.reply_data == WORD_FF00) ? 1'b0 : 1'b1;
                end
                CMD_READ_ANALOG: begin
                  v = int'(sample);
                  d0 = 8'(48 + v / 1000);
                  d1 = 8'(48 + (v / 100) % 10);
                  d2 = 8'(48 + (v / 10) % 10);
                  d3 = 8'(48 + v % 10);
                  ans.reply_data = {d0, d1, d2, d3};
                end
                default: begin
                  // Non-digits count as zero; saturate the level at 255
                  v = 0;
                  for (int k = 7; k < 11; k++) begin
                    v = v * 10 + (dec_char(line_buf[k]) ? digit_of(line_buf[k]) : 0);
                  end
                  aout_lvl = (v > 255) ? 8'hFF : 8'(v);
                  ans.reply_data = {d0, d1, d2, d3};
                end
              endcase
            end
          end
        end
      end
      if (ans.frame_status == ST_BAD_COMMAND) chn = 0;
      ans.command_code = 7'(cmd);
      ans.channel_number = 7'(chn);
      ans.coil_drive = coil_lvl;
      ans.analog_drive = aout_lvl;
      answers_q.push_back(ans);
    end
  endtask

  // Match result requests first, then fold in the accepted character request
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LINE_MAX; k++) line_buf[k] = '0;
      line_len = '0;
      coil_lvl = COIL_LEVELS_RESET;
      aout_lvl = ANALOG_LEVEL_RESET;
      our_addr = SLAVE_ADDRESS_RESET;
      answers_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: result with none expected, actual %h", $time, out_item);
        end else begin
          want = answers_q.pop_front();
          compare_field("frame_status", 32'(want.frame_status),
                        32'(out_item.frame_status));
          compare_field("command_code", 32'(want.command_code),
                        32'(out_item.command_code));
          compare_field("channel_number", 32'(want.channel_number),
                        32'(out_item.channel_number));
          compare_field("reply_data", want.reply_data, out_item.reply_data);
          compare_field("coil_drive", 32'(want.coil_drive), 32'(out_item.coil_drive));
          compare_field("analog_drive", 32'(want.analog_drive),
                        32'(out_item.analog_drive));
        end
      end
      if (in_valid && !in_stall) decode_char(in_item);
      if (cfg_we) our_addr = cfg_wdata;
    end
    pending <= answers_q.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import afs_lrc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 105;
  localparam int NUM_PHASES = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int holds_seen = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int chars_sent = 0;
  logic [7:0] cur_addr = SLAVE_ADDRESS_RESET;
  logic [7:0] line_q [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  ascii_frame_slave_with_lrc i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  afs_lrc_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall results at random; hold off for a long stretch on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_seen != hold_reqs) begin
      holds_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Give up when no request moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + n : 8'd55 + n;
  endfunction

  function automatic logic [7:0] hex_val(input logic [7:0] c);
    return (c > CHAR_NINE) ? c - 8'd55 : c - 8'd48;
  endfunction

  function automatic logic [15:0] addr_hex(input logic [7:0] a);
    return {hex_char(a[7:4]), hex_char(a[3:0])};
  endfunction

  function automatic logic [15:0] dec2(input int n);
    logic [7:0] hi, lo;
    hi = 8'(48 + n / 10);
    lo = 8'(48 + n % 10);
    return {hi, lo};
  endfunction

  function automatic logic [7:0] rand_char();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_hex();
    return hex_char(4'($urandom_range(15)));
  endfunction

  // Favor the ends of the sample range
  function automatic logic [9:0] pick_analog();
    case ($urandom_range(9))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [7:0] c);
    in_item_t it;
    it.rx_char = c;
    it.digital_inputs = 4'($urandom_range(15));
    it.analog_in_one = pick_analog();
    it.analog_in_two = pick_analog();
    it.analog_in_three = pick_analog();
    it.analog_in_four = pick_analog();
    return it;
  endfunction

  // Assemble ':' + ten body characters + LRC, optionally spoiled, optional CR
  task automatic build_frame(input logic [79:0] body, input logic [7:0] flip,
                             input bit with_cr);
    logic [7:0] sum, hn, ln, lrc;
    line_q.delete();
    sum = '0;
    line_q.push_back(CHAR_COLON);
    for (int k = 0; k < 10; k++) line_q.push_back(body[79 - 8 * k -: 8]);
    for (int k = 0; k < 5; k++) begin
      hn = hex_val(body[79 - 16 * k -: 8]);
      ln = hex_val(body[71 - 16 * k -: 8]);
      sum = sum + {hn[3:0], 4'h0} + ln;
    end
    lrc = (~sum + 8'd1) ^ flip;
    line_q.push_back(hex_char(lrc[7:4]));
    line_q.push_back(hex_char(lrc[3:0]));
    if (with_cr) line_q.push_back(CHAR_CR);
  endtask

  // Offer one character request, idling first at random, and hold until taken
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= make_item(c);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent = chars_sent + 1;
  endtask

  task automatic send_line();
    foreach (line_q[k]) send_char(line_q[k]);
    send_char(CHAR_LF);
  endtask

  // Wait until every answer is in and the pipeline is quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] a);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_addr = a;
  endtask

  // Mostly well-formed frames with random content, some noise and damage
  task automatic send_random_line();
    logic [15:0] addr_s, cmd_s, chan_s;
    logic [31:0] data_s;
    logic [7:0]  flip;
    logic [6:0]  cmd;
    int          pick, n;
    line_q.delete();
    if ($urandom_range(99) < 4) begin
      repeat ($urandom_range(24)) line_q.push_back(rand_char());
      send_line();
    end else begin
      case ($urandom_range(4))
        0: cmd = CMD_READ_COIL;
        1: cmd = CMD_READ_INPUT;
        2: cmd = CMD_WRITE_COIL;
        3: cmd = CMD_READ_ANALOG;
        default: cmd = CMD_WRITE_ANALOG;
      endcase
      pick = $urandom_range(99);
      if (pick < 3) addr_s = {rand_char(), rand_char()};
      else if (pick < 12) addr_s = addr_hex(8'($urandom_range(255)));
      else addr_s = addr_hex(cur_addr);
      case ($urandom_range(9))
        0: cmd_s = {rand_char(), rand_char()};
        1: cmd_s = dec2($urandom_range(99));
        default: cmd_s = dec2(cmd);
      endcase
      case ($urandom_range(9))
        0: chan_s = {rand_char(), rand_char()};
        1: chan_s = dec2($urandom_range(99));
        default: chan_s = dec2((cmd == CMD_WRITE_ANALOG) ? 1 : $urandom_range(1, 4));
      endcase
      pick = $urandom_range(9);
      if (cmd == CMD_WRITE_COIL && pick < 5) begin
        data_s = WORD_FF00;
      end else if (cmd == CMD_WRITE_ANALOG && pick < 6) begin
        n = $urandom_range(400);
        data_s = {dec2(n / 100), dec2(n % 100)};
      end else if (pick < 8) begin
        data_s = {rand_hex(), rand_hex(), rand_hex(), rand_hex()};
      end else begin
        data_s = {rand_char(), rand_char(), rand_char(), rand_char()};
      end
      flip = ($urandom_range(99) < 8) ? 8'($urandom_range(1, 255)) : 8'd0;
      build_frame({addr_s, cmd_s, chan_s, data_s}, flip, 1'($urandom_range(1)));
      // Damage a few frames: start mark, dropped, inserted or trailing characters
      pick = $urandom_range(99);
      if (pick < 3) line_q[0] = rand_char();
      else if (pick < 6) line_q.delete($urandom_range(line_q.size() - 1));
      else if (pick < 9) line_q.insert($urandom_range(line_q.size()), rand_char());
      else if (pick < 11) repeat ($urandom_range(1, 6)) line_q.push_back(rand_char());
      send_line();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_address(SLAVE_ADDRESS_RESET);

    // Empty line
    line_q.delete();
    send_line();
    // Coil reads and writes, input and analog reads on valid channels, with and without CR
    build_frame({addr_hex(cur_addr), "01010000"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "0502FF00"}, 8'h00, 1'b1);
    send_line();
    build_frame({addr_hex(cur_addr), "01020000"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "05020000"}, 8'h00, 1'b1);
    send_line();
    build_frame({addr_hex(cur_addr), "02040000"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "06030000"}, 8'h00, 1'b0);
    send_line();
    // Analog writes: saturation, plain value, non-digit as zero, wrong channel
    build_frame({addr_hex(cur_addr), "07010300"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "07010042"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "070100A7"}, 8'h00, 1'b1);
    send_line();
    build_frame({addr_hex(cur_addr), "07020100"}, 8'h00, 1'b0);
    send_line();
    // Bad start, bad LRC, another slave, non-hex address
    build_frame({addr_hex(cur_addr), "01010000"}, 8'h00, 1'b0);
    line_q[0] = ";";
    send_line();
    build_frame({addr_hex(cur_addr), "01010000"}, 8'h01, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr + 8'd1), "01010000"}, 8'h00, 1'b0);
    send_line();
    build_frame({"G?", "01010000"}, 8'h00, 1'b0);
    send_line();
    // Non-decimal and unknown commands
    build_frame({addr_hex(cur_addr), "1A010000"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "09010000"}, 8'h00, 1'b0);
    send_line();
    // Channel zero, past the last one, and non-decimal
    build_frame({addr_hex(cur_addr), "01000000"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "01050000"}, 8'h00, 1'b0);
    send_line();
    build_frame({addr_hex(cur_addr), "010Z0000"}, 8'h00, 1'b0);
    send_line();
    // Overlong line with extreme character codes
    line_q.delete();
    line_q.push_back(8'hFF);
    line_q.push_back(8'h80);
    line_q.push_back(8'h00);
    repeat (17) line_q.push_back(rand_hex());
    send_line();
    // Twelve characters, then fourteen without a CR
    build_frame({addr_hex(cur_addr), "01010000"}, 8'h00, 1'b0);
    void'(line_q.pop_back());
    send_line();
    build_frame({addr_hex(cur_addr), "01010000"}, 8'h00, 1'b0);
    line_q.push_back("7");
    send_line();

    // Random phases over several addresses and idle patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_address(8'h00);
        1: set_address(8'hFF);
        2: set_address(SLAVE_ADDRESS_RESET);
        default: set_address(8'($urandom_range(255)));
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct = 17;
        end
      endcase
      // Back up the output while characters keep coming
      if (ph == 4) hold_reqs = hold_reqs + 1;
      chars_sent = 0;
      while (chars_sent < PHASE_CHARS) send_random_line();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
